// ===== rtl/aps_pkg.sv =====
// Shared types and constants for the aging priority job scheduler.
`default_nettype none
package aps_pkg;

    localparam int SLOTS       = 16;
    localparam int ID_BITS     = 16;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int WAIT_W      = 16;
    localparam int ELAPSED_W   = 12;
    localparam int QUANTUM_W   = 10;
    localparam int PRIO_W      = 3;
    localparam int MAX_RESULTS = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [PRIO_W-1:0]    PRIO_CEILING    = 3'd3;
    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET   = 10'd100;
    localparam logic [PRIO_W-1:0]    INIT_PRIO_RESET = 3'd3;

    // Job states
    localparam logic [2:0] ST_INIT    = 3'd0;
    localparam logic [2:0] ST_READY   = 3'd1;
    localparam logic [2:0] ST_RUNNING = 3'd2;
    localparam logic [2:0] ST_WAIT    = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AGING_QUANTUM    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PRIORITY = 1'd1;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_TICK    = 2'd2,
        OP_STATUS  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT,
        CELL_LOAD
    } cell_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENQ,
        S_DEQ,
        S_PURGE,
        S_FIND,
        S_WALK,
        S_SWITCH,
        S_STAT
    } fsm_t;

    typedef struct packed {
        logic               used;
        logic [ID_BITS-1:0] id;
        logic [2:0]         status;
        logic [PRIO_W-1:0]  prio;
        logic [WAIT_W-1:0]  waited;
    } entry_t;

endpackage
`default_nettype wire

// ===== rtl/aps_cell.sv =====
// One slot of the job table: holds an entry, takes a neighbor's or a loaded entry.
`default_nettype none
module aps_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire aps_pkg::cell_cmd_t cmd,
    input  wire aps_pkg::entry_t   left,
    input  wire aps_pkg::entry_t   right,
    input  wire aps_pkg::entry_t   load,
    output aps_pkg::entry_t        q
);
    import aps_pkg::*;

    logic   used_reg;
    entry_t data_reg;
    entry_t data_next;

    always_comb
    begin
        case (cmd)
            CELL_HOLD:       data_next = q;
            CELL_TAKE_LEFT:  data_next = left;
            CELL_TAKE_RIGHT: data_next = right;
            CELL_LOAD:       data_next = load;
            default:         data_next = q;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= data_next.used;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        q      = data_reg;
        q.used = used_reg;
    end

endmodule
`default_nettype wire

// ===== rtl/aging_priority_job_scheduler_top.sv =====
// Top level of the aging priority job scheduler: slot chain and sequencer.
//
// Usage:
//   Input stream s_*: s_tuser = operation (enqueue, dequeue, tick, status);
//   s_tdata carries target_id, elapsed_ms and current_finished. One transfer
//   is taken only while the sequencer is idle.
//   Output stream m_*: one result per enqueue, dequeue or tick, one per listed
//   job for status (or a single entry_valid=0 item on an empty table);
//   m_tlast marks the final result of an operation, m_tuser its kind.
//   Config channel cfg_*: index 0 aging quantum, 1 initial priority; always ready.
// Table: the chain has 16 cells. Enqueue and the tick walk shift all cells
//   together; dequeue and the purge step of a tick remove one job per cycle by
//   shifting the cells at and above it. A tick then finds the running job,
//   rotates the chain once through the aging unit at its head and applies the
//   switch. Status rotates a non-empty chain once, holding while a result waits.
// Stall: a result waits in the output register; the sequencer holds at the next
//   result until it is taken, and a new input is accepted meanwhile once idle.
// Reset: table empty, no running job, id counter 0, quantum 100, priority 3.
`default_nettype none
module aging_priority_job_scheduler_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // target_id[15:0], elapsed_ms[27:16], current_finished[28]
    input  wire logic [1:0]  s_tuser,   // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // ok[0], job_number[16:1], prior_job[32:17],
                                        // switched[33], job_state[36:34], entry_valid[37]
    output logic [1:0]       m_tuser,   // reply_kind
    output logic             m_tlast,   // last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [aps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [9:0]  cfg_data
);
    import aps_pkg::*;

    // Slot chain
    entry_t    cells_q [SLOTS];
    cell_cmd_t cmd     [SLOTS];
    entry_t    load_d  [SLOTS];
    entry_t    left0;
    entry_t    right_last;

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        entry_t left_in;
        entry_t right_in;
        if (k == 0)
        begin : g_first
            assign left_in = left0;
        end
        else
        begin : g_mid_l
            assign left_in = cells_q[k-1];
        end
        if (k == SLOTS - 1)
        begin : g_last
            assign right_in = right_last;
        end
        else
        begin : g_mid_r
            assign right_in = cells_q[k+1];
        end
        aps_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd[k]),
            .left  (left_in),
            .right (right_in),
            .load  (load_d[k]),
            .q     (cells_q[k])
        );
    end

    // Control state
    fsm_t                 state_reg, state_next;
    logic [QUANTUM_W-1:0] quantum_reg;
    logic [PRIO_W-1:0]    init_prio_reg;
    logic [ID_BITS-1:0]   id_cnt_reg, id_cnt_next;
    logic                 rv_reg, rv_next;
    logic [ID_BITS-1:0]   run_id_reg, run_id_next;
    logic [IDX_W-1:0]     step_reg, step_next;
    logic                 found_reg, found_next;
    logic                 cur_v_reg, cur_v_next;
    logic                 next_v_reg, next_v_next;
    logic                 out_valid_reg, out_valid_next;

    // Operation and walk payload
    logic [ID_BITS-1:0]   target_reg, target_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic                 fin_reg, fin_next;
    logic [PRIO_W-1:0]    best_reg, best_next;
    logic [IDX_W-1:0]     cur_idx_reg, cur_idx_next;
    logic [ID_BITS-1:0]   cur_id_reg, cur_id_next;
    logic [IDX_W-1:0]     next_idx_reg, next_idx_next;
    logic [ID_BITS-1:0]   next_id_reg, next_id_next;

    // Output register
    logic [1:0]           o_kind_reg, o_kind_next;
    logic                 o_ok_reg, o_ok_next;
    logic [15:0]          o_job_reg, o_job_next;
    logic [15:0]          o_prior_reg, o_prior_next;
    logic                 o_sw_reg, o_sw_next;
    logic [2:0]           o_state_reg, o_state_next;
    logic                 o_ev_reg, o_ev_next;
    logic                 o_last_reg, o_last_next;

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    // First-match searches over the chain
    logic             dq_hit, done_hit, run_hit;
    logic [IDX_W-1:0] dq_idx, done_idx, run_idx;

    always_comb
    begin
        dq_hit   = 1'b0;
        done_hit = 1'b0;
        run_hit  = 1'b0;
        dq_idx   = '0;
        done_idx = '0;
        run_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (cells_q[i].used && cells_q[i].id == target_reg)
            begin
                dq_hit = 1'b1;
                dq_idx = IDX_W'(i);
            end
            if (cells_q[i].used && cells_q[i].status == ST_DONE)
            begin
                done_hit = 1'b1;
                done_idx = IDX_W'(i);
            end
            if (cells_q[i].used && cells_q[i].id == run_id_reg)
            begin
                run_hit = 1'b1;
                run_idx = IDX_W'(i);
            end
        end
    end

    // Aging unit at the head of the chain
    entry_t            head, head_new;
    logic              elig, ge, cand;
    logic [WAIT_W:0]   wait_sum;
    logic [WAIT_W-1:0] wait_sat, wait_a;
    logic [PRIO_W-1:0] prio_a;

    always_comb
    begin
        head     = cells_q[0];
        elig     = head.used && (head.status == ST_READY || head.status == ST_WAIT);
        wait_sum = {1'b0, head.waited} + (WAIT_W+1)'(elapsed_reg);
        wait_sat = wait_sum[WAIT_W] ? {WAIT_W{1'b1}} : wait_sum[WAIT_W-1:0];
        ge       = wait_sat >= WAIT_W'(quantum_reg);
        prio_a   = head.prio;
        wait_a   = wait_sat;
        if (ge && head.prio != '0)
        begin
            prio_a = head.prio - 1'b1;
            wait_a = wait_sat - WAIT_W'(quantum_reg);
        end
        cand     = elig && ge && (prio_a < best_reg);
        head_new = head;
        if (elig)
        begin
            head_new.prio   = prio_a;
            head_new.waited = wait_a;
        end
    end

    logic [IDX_W:0] step_ext;
    assign step_ext = {1'b0, step_reg};

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        id_cnt_next   = id_cnt_reg;
        rv_next       = rv_reg;
        run_id_next   = run_id_reg;
        step_next     = step_reg;
        found_next    = found_reg;
        cur_v_next    = cur_v_reg;
        next_v_next   = next_v_reg;
        target_next   = target_reg;
        elapsed_next  = elapsed_reg;
        fin_next      = fin_reg;
        best_next     = best_reg;
        cur_idx_next  = cur_idx_reg;
        cur_id_next   = cur_id_reg;
        next_idx_next = next_idx_reg;
        next_id_next  = next_id_reg;

        out_valid_next = out_valid_reg && !m_tready;
        o_kind_next    = o_kind_reg;
        o_ok_next      = o_ok_reg;
        o_job_next     = o_job_reg;
        o_prior_next   = o_prior_reg;
        o_sw_next      = o_sw_reg;
        o_state_next   = o_state_reg;
        o_ev_next      = o_ev_reg;
        o_last_next    = o_last_reg;

        for (int k = 0; k < SLOTS; k++)
        begin
            cmd[k]    = CELL_HOLD;
            load_d[k] = cells_q[k];
        end
        left0        = '{used: 1'b1, id: id_cnt_reg, status: ST_READY,
                         prio: '0, waited: '0};
        right_last   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    target_next  = s_tdata[15:0];
                    elapsed_next = s_tdata[27:16];
                    fin_next     = s_tdata[28];
                    step_next    = '0;
                    found_next   = 1'b0;
                    case (op_t'(s_tuser))
                        OP_ENQUEUE: state_next = S_ENQ;
                        OP_DEQUEUE: state_next = S_DEQ;
                        OP_TICK:    state_next = S_PURGE;
                        OP_STATUS:  state_next = S_STAT;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end

            S_ENQ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_kind_next    = OP_ENQUEUE;
                    o_prior_next   = '0;
                    o_sw_next      = 1'b0;
                    o_state_next   = ST_INIT;
                    o_ev_next      = 1'b1;
                    o_last_next    = 1'b1;
                    if (cells_q[SLOTS-1].used)
                    begin
                        o_ok_next  = 1'b0;
                        o_job_next = '0;
                    end
                    else
                    begin
                        o_ok_next  = 1'b1;
                        o_job_next = id_cnt_reg;
                        for (int k = 0; k < SLOTS; k++)
                        begin
                            cmd[k] = CELL_TAKE_LEFT;
                        end
                        id_cnt_next = id_cnt_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_DEQ:
            begin
                if (dq_hit)
                begin
                    // close the gap: cells at and above the match take from the right
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        if (IDX_W'(k) >= dq_idx)
                        begin
                            cmd[k] = CELL_TAKE_RIGHT;
                        end
                    end
                    found_next = 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_kind_next    = OP_DEQUEUE;
                    o_ok_next      = found_reg;
                    o_job_next     = '0;
                    o_prior_next   = '0;
                    o_sw_next      = 1'b0;
                    o_state_next   = ST_INIT;
                    o_ev_next      = 1'b1;
                    o_last_next    = 1'b1;
                    if (rv_reg && run_id_reg == target_reg)
                    begin
                        rv_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end

            S_PURGE:
            begin
                if (done_hit)
                begin
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        if (IDX_W'(k) >= done_idx)
                        begin
                            cmd[k] = CELL_TAKE_RIGHT;
                        end
                    end
                end
                else
                begin
                    state_next = S_FIND;
                end
            end

            S_FIND:
            begin
                cur_v_next = 1'b0;
                if (fin_reg && rv_reg)
                begin
                    if (run_hit)
                    begin
                        cmd[run_idx]           = CELL_LOAD;
                        load_d[run_idx].status = ST_DONE;
                    end
                    rv_next = 1'b0;
                end
                else if (rv_reg && run_hit)
                begin
                    cur_v_next   = 1'b1;
                    cur_idx_next = run_idx;
                    cur_id_next  = run_id_reg;
                end
                else
                begin
                    rv_next = 1'b0;
                end
                step_next   = '0;
                best_next   = PRIO_CEILING;
                next_v_next = 1'b0;
                state_next  = S_WALK;
            end

            S_WALK:
            begin
                // rotate the chain once; the head passes through the aging unit
                for (int k = 0; k < SLOTS; k++)
                begin
                    cmd[k] = CELL_TAKE_RIGHT;
                end
                right_last = head_new;
                if (elig && !cur_v_reg)
                begin
                    cur_v_next   = 1'b1;
                    cur_idx_next = step_reg;
                    cur_id_next  = head.id;
                    rv_next      = 1'b1;
                    run_id_next  = head.id;
                end
                if (cand)
                begin
                    best_next     = prio_a;
                    next_v_next   = 1'b1;
                    next_idx_next = step_reg;
                    next_id_next  = head.id;
                end
                step_next = step_reg + 1'b1;
                if (step_ext == (IDX_W+1)'(SLOTS - 1))
                begin
                    state_next = S_SWITCH;
                end
            end

            S_SWITCH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_kind_next    = OP_TICK;
                    o_ok_next      = 1'b0;
                    o_state_next   = ST_INIT;
                    o_ev_next      = 1'b1;
                    o_last_next    = 1'b1;
                    o_sw_next      = next_v_reg;
                    o_job_next     = next_v_reg ? next_id_reg : '0;
                    o_prior_next   = next_v_reg ? cur_id_reg : '0;
                    if (next_v_reg)
                    begin
                        for (int k = 0; k < SLOTS; k++)
                        begin
                            if (IDX_W'(k) == cur_idx_reg)
                            begin
                                cmd[k]           = CELL_LOAD;
                                load_d[k].prio   = init_prio_reg;
                                load_d[k].waited = '0;
                                load_d[k].status = ST_WAIT;
                            end
                            if (IDX_W'(k) == next_idx_reg)
                            begin
                                cmd[k]           = CELL_LOAD;
                                load_d[k].status = ST_RUNNING;
                            end
                        end
                        run_id_next = next_id_reg;
                        rv_next     = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_STAT:
            begin
                if (step_reg == '0 && !head.used)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        o_kind_next    = OP_STATUS;
                        o_ok_next      = 1'b0;
                        o_job_next     = '0;
                        o_prior_next   = '0;
                        o_sw_next      = 1'b0;
                        o_state_next   = ST_INIT;
                        o_ev_next      = 1'b0;
                        o_last_next    = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (!(head.used && step_ext < (IDX_W+1)'(MAX_RESULTS)) || out_free)
                begin
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        cmd[k] = CELL_TAKE_RIGHT;
                    end
                    right_last = head;
                    if (head.used && step_ext < (IDX_W+1)'(MAX_RESULTS))
                    begin
                        out_valid_next = 1'b1;
                        o_kind_next    = OP_STATUS;
                        o_ok_next      = 1'b0;
                        o_job_next     = 16'(head.id);
                        o_prior_next   = '0;
                        o_sw_next      = 1'b0;
                        o_state_next   = head.status;
                        o_ev_next      = 1'b1;
                        o_last_next    = !cells_q[1].used
                                      || step_ext == (IDX_W+1)'(SLOTS - 1)
                                      || step_ext == (IDX_W+1)'(MAX_RESULTS - 1);
                    end
                    step_next = step_reg + 1'b1;
                    if (step_ext == (IDX_W+1)'(SLOTS - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            quantum_reg   <= QUANTUM_RESET;
            init_prio_reg <= INIT_PRIO_RESET;
            id_cnt_reg    <= '0;
            rv_reg        <= 1'b0;
            run_id_reg    <= '0;
            step_reg      <= '0;
            found_reg     <= 1'b0;
            cur_v_reg     <= 1'b0;
            next_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            id_cnt_reg    <= id_cnt_next;
            rv_reg        <= rv_next;
            run_id_reg    <= run_id_next;
            step_reg      <= step_next;
            found_reg     <= found_next;
            cur_v_reg     <= cur_v_next;
            next_v_reg    <= next_v_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_AGING_QUANTUM:    quantum_reg   <= cfg_data;
                    REG_INITIAL_PRIORITY: init_prio_reg <= cfg_data[PRIO_W-1:0];
                    default:              quantum_reg   <= quantum_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        elapsed_reg  <= elapsed_next;
        fin_reg      <= fin_next;
        best_reg     <= best_next;
        cur_idx_reg  <= cur_idx_next;
        cur_id_reg   <= cur_id_next;
        next_idx_reg <= next_idx_next;
        next_id_reg  <= next_id_next;
        o_kind_reg   <= o_kind_next;
        o_ok_reg     <= o_ok_next;
        o_job_reg    <= o_job_next;
        o_prior_reg  <= o_prior_next;
        o_sw_reg     <= o_sw_next;
        o_state_reg  <= o_state_next;
        o_ev_reg     <= o_ev_next;
        o_last_reg   <= o_last_next;
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = o_kind_reg;
    assign m_tlast   = o_last_reg;
    assign m_tdata   = {2'b00, o_ev_reg, o_state_reg, o_sw_reg, o_prior_reg,
                        o_job_reg, o_ok_reg};

endmodule
`default_nettype wire
